FILE: sv/swpg_pkg.sv
// package for the spoke wheel pattern generator
// field widths, register indexes, cordic turn table and shared types
// no dependencies
package swpg_pkg;

  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int VAL_W      = 2;
  localparam int SIDE_W     = 11;
  localparam int SPOKE_W    = 8;
  localparam int PHASE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ZW         = 32;
  localparam int FRAC_BITS  = 20;
  localparam int TAB_LEN    = 26;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPOKE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 2'd2;

  localparam logic [SIDE_W-1:0]  SIDE_RESET  = 11'd256;
  localparam logic [SPOKE_W-1:0] SPOKE_RESET = 8'd8;
  localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd0;

  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [ZW-1:0] TURN_ATAN [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014
  };

  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [COL_W-1:0]          col_t;
  typedef logic signed [VAL_W-1:0]   pixel_value_t;

  localparam pixel_value_t VAL_POS  = 2'sb01;
  localparam pixel_value_t VAL_NEG  = 2'sb11;
  localparam pixel_value_t VAL_ZERO = 2'sb00;

  typedef struct packed {
    logic zero;
    logic neg;
  } swpg_flag_t;

endpackage

FILE: sv/swpg_req_if.sv
// request channel: pixel position
// depends on swpg_pkg
interface swpg_req_if;
  import swpg_pkg::*;

  logic valid;
  logic ready;
  row_t pixel_row;
  col_t pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);

endinterface

FILE: sv/swpg_res_if.sv
// result channel: one pattern pixel
// depends on swpg_pkg
interface swpg_res_if;
  import swpg_pkg::*;

  logic         valid;
  logic         ready;
  pixel_value_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);

endinterface

FILE: sv/swpg_prep.sv
// front stage: side clamp, mirror fold, centre offsets and half-turn pre-rotation
// depends on swpg_pkg
module swpg_prep #(
  parameter int MAX_SIDE = 1024,
  parameter int XY_W     = 34
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  swpg_pkg::row_t                row,
  input  swpg_pkg::col_t                col,
  input  logic [swpg_pkg::SIDE_W-1:0]   image_side,
  input  logic                          spoke_odd,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic signed [XY_W-1:0]        x,
  output logic signed [XY_W-1:0]        y,
  output logic [swpg_pkg::ZW-1:0]       z,
  output swpg_pkg::swpg_flag_t          flag
);
  import swpg_pkg::*;

  localparam int NW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = (NW > SIDE_W) ? NW : SIDE_W;

  logic [CMPW-1:0]        side_ext, n, h, r, c, rd, cd;
  logic                   outside, mirror, centre;
  logic signed [CMPW:0]   xd, yd;
  logic signed [XY_W-1:0] xw, yw, x_next, y_next;
  logic [ZW-1:0]          z_next;
  swpg_flag_t             flag_next;

  always_comb begin
    side_ext = CMPW'(image_side);
    if (side_ext < CMPW'(2)) begin
      n = CMPW'(2);
    end else if (side_ext > CMPW'(MAX_SIDE)) begin
      n = CMPW'(MAX_SIDE);
    end else begin
      n = side_ext;
    end
    h = n >> 1;
    r = CMPW'(row);
    c = CMPW'(col);
    outside = (r >= n) || (c >= n) || (r == '0) || (c == '0);
    mirror  = (r > h) || (!n[0] && (r == h) && (c < h));
    rd = mirror ? (n - r) : r;
    cd = mirror ? (n - c) : c;
    xd = $signed({1'b0, rd}) - $signed({1'b0, h});
    yd = $signed({1'b0, cd}) - $signed({1'b0, h});
    centre = (xd == '0) && (yd == '0);
    flag_next.zero = outside || centre;
    flag_next.neg  = mirror && spoke_odd;
    xw = XY_W'(xd) <<< FRAC_BITS;
    yw = XY_W'(yd) <<< FRAC_BITS;
    if (xw < 0) begin
      x_next = -xw;
      y_next = -yw;
      z_next = HALF_TURN;
    end else begin
      x_next = xw;
      y_next = yw;
      z_next = '0;
    end
  end

  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      flag <= flag_next;
    end
  end

  a_edge_zero : assert property (@(posedge clk) disable iff (rst)
    in_vld && in_rdy && ((row == '0) || (col == '0)) |=> out_vld && flag.zero)
    else $error("edge pixel not marked zero");

  a_x_folded : assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !x[XY_W-1])
    else $error("x negative after half-turn fold");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_rdy |=> out_vld && $stable(z) && $stable(flag))
    else $error("front stage lost a stalled request");

endmodule

FILE: sv/swpg_cell.sv
// one cordic vectoring cell: rotates by +/- atan(2^-SHIFT) toward y = 0
// depends on swpg_pkg
module swpg_cell #(
  parameter int                       XY_W  = 34,
  parameter int                       SHIFT = 0,
  parameter logic [swpg_pkg::ZW-1:0]  ATAN  = '0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  output logic                        in_rdy,
  input  logic signed [XY_W-1:0]      x_in,
  input  logic signed [XY_W-1:0]      y_in,
  input  logic [swpg_pkg::ZW-1:0]     z_in,
  input  swpg_pkg::swpg_flag_t        flag_in,
  output logic                        out_vld,
  input  logic                        out_rdy,
  output logic signed [XY_W-1:0]      x,
  output logic signed [XY_W-1:0]      y,
  output logic [swpg_pkg::ZW-1:0]     z,
  output swpg_pkg::swpg_flag_t        flag
);
  import swpg_pkg::*;

  logic signed [XY_W-1:0] dx, dy, x_next, y_next;
  logic [ZW-1:0]          z_next;

  always_comb begin
    dx = y_in >>> SHIFT;
    dy = x_in >>> SHIFT;
    if (y_in > 0) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ATAN;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ATAN;
    end
  end

  assign in_rdy = !out_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_rdy) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      flag <= flag_in;
    end
  end

endmodule

FILE: sv/swpg_mix.sv
// spoke multiply with phase add, then sine sign and output register
// depends on swpg_pkg
module swpg_mix #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic [swpg_pkg::ZW-1:0]       z_in,
  input  swpg_pkg::swpg_flag_t          flag_in,
  input  logic [swpg_pkg::SPOKE_W-1:0]  spoke_count,
  input  logic [swpg_pkg::PHASE_W-1:0]  phase_offset,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output swpg_pkg::pixel_value_t        pixel_value
);
  import swpg_pkg::*;

  localparam int PW = SPOKE_W + ANGLE_BITS;

  logic [ANGLE_BITS-1:0] theta, phase_s, a_next, a;
  logic [PW-1:0]         prod;
  logic                  a_vld, b_rdy, pos;
  swpg_flag_t            a_flag;
  pixel_value_t          value_next;

  generate
    if (ANGLE_BITS >= PHASE_W) begin : g_phase_up
      assign phase_s = ANGLE_BITS'(phase_offset) << (ANGLE_BITS - PHASE_W);
    end else begin : g_phase_down
      assign phase_s = phase_offset[PHASE_W-1 -: ANGLE_BITS];
    end
  endgenerate

  always_comb begin
    theta  = z_in[ZW-1 -: ANGLE_BITS];
    prod   = PW'(spoke_count) * PW'(theta);
    a_next = prod[ANGLE_BITS-1:0] + phase_s;
  end

  always_comb begin
    pos = (a != '0) && !a[ANGLE_BITS-1];
    if (a_flag.zero) begin
      value_next = VAL_ZERO;
    end else if (pos ^ a_flag.neg) begin
      value_next = VAL_POS;
    end else begin
      value_next = VAL_NEG;
    end
  end

  assign b_rdy  = !out_vld || out_rdy;
  assign in_rdy = !a_vld || b_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (in_rdy) begin
        a_vld <= in_vld;
      end
      if (b_rdy) begin
        out_vld <= a_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      a      <= a_next;
      a_flag <= flag_in;
    end
    if (a_vld && b_rdy) begin
      pixel_value <= value_next;
    end
  end

endmodule

FILE: sv/spoke_wheel_pattern_generator_unit.sv
// top level of the spoke wheel pattern generator: config registers and the cell chain
// depends on swpg_pkg, swpg_req_if, swpg_res_if, swpg_prep, swpg_cell, swpg_mix
//
//   port   dir   payload                  handshake
//   req    in    pixel_row, pixel_col     valid / ready
//   res    out   pixel_value              valid / ready
//   cfg    in    cfg_index, cfg_wdata     cfg_wr_en, no back-pressure
//
// one pixel per clock sustained while res.ready holds; a pixel passes through the
// front stage, ANGLE_BITS + 2 cordic cells at most, multiply stage, output register
// synchronous reset clears valids and loads register defaults
// each stage moves on when the next one is empty or moving, so bubbles collapse
module spoke_wheel_pattern_generator_unit #(
  parameter int MAX_SIDE   = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [swpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swpg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  swpg_req_if.sink                         req,
  swpg_res_if.source                       res
);
  import swpg_pkg::*;

  localparam int NW     = $clog2(MAX_SIDE + 1);
  localparam int XY_W   = NW + 3 + FRAC_BITS;
  localparam int STAGES = (ANGLE_BITS + 2 > TAB_LEN) ? TAB_LEN : ANGLE_BITS + 2;

  logic [SIDE_W-1:0]  image_side;
  logic [SPOKE_W-1:0] spoke_count;
  logic [PHASE_W-1:0] phase_offset;

  logic                   vld [STAGES+1];
  logic                   rdy [STAGES+1];
  logic signed [XY_W-1:0] xs  [STAGES+1];
  logic signed [XY_W-1:0] ys  [STAGES+1];
  logic [ZW-1:0]          zs  [STAGES+1];
  swpg_flag_t             fl  [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side   <= SIDE_RESET;
      spoke_count  <= SPOKE_RESET;
      phase_offset <= PHASE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_SIDE:   image_side   <= cfg_wdata[SIDE_W-1:0];
        REG_SPOKE_COUNT:  spoke_count  <= cfg_wdata[SPOKE_W-1:0];
        REG_PHASE_OFFSET: phase_offset <= cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  swpg_prep #(
    .MAX_SIDE (MAX_SIDE),
    .XY_W     (XY_W)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (req.valid),
    .in_rdy     (req.ready),
    .row        (req.pixel_row),
    .col        (req.pixel_col),
    .image_side (image_side),
    .spoke_odd  (spoke_count[0]),
    .out_vld    (vld[0]),
    .out_rdy    (rdy[0]),
    .x          (xs[0]),
    .y          (ys[0]),
    .z          (zs[0]),
    .flag       (fl[0])
  );

  generate
    for (genvar i = 0; i < STAGES; i++) begin : g_cell
      swpg_cell #(
        .XY_W  (XY_W),
        .SHIFT (i),
        .ATAN  (TURN_ATAN[i])
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .in_vld  (vld[i]),
        .in_rdy  (rdy[i]),
        .x_in    (xs[i]),
        .y_in    (ys[i]),
        .z_in    (zs[i]),
        .flag_in (fl[i]),
        .out_vld (vld[i+1]),
        .out_rdy (rdy[i+1]),
        .x       (xs[i+1]),
        .y       (ys[i+1]),
        .z       (zs[i+1]),
        .flag    (fl[i+1])
      );
    end
  endgenerate

  swpg_mix #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_mix (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (vld[STAGES]),
    .in_rdy       (rdy[STAGES]),
    .z_in         (zs[STAGES]),
    .flag_in      (fl[STAGES]),
    .spoke_count  (spoke_count),
    .phase_offset (phase_offset),
    .out_vld      (res.valid),
    .out_rdy      (res.ready),
    .pixel_value  (res.pixel_value)
  );

endmodule
